/* rtl/epsm_pkg.sv */
// Package for the encoder period speed meter.
// Widths, register reset values, codes, sequencer states and the
// divider handshake structs. Depends on nothing.
package epsm_pkg;

    localparam int CAP_W   = 32;
    localparam int FREQ_W  = 32;
    localparam int RPM_W   = 32;
    localparam int TCK_W   = 28;
    localparam int EPC_W   = 4;
    localparam int PPR_W   = 11;
    localparam int TMO_W   = 16;
    localparam int IDLE_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // divider: dividend wide enough for freq * 60, divisor wide enough for a period
    localparam int DIV_NUM_W = FREQ_W + 6;
    localparam int DIV_DEN_W = CAP_W;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] FREQ_STEPS = DIV_CNT_W'(FREQ_W);
    localparam logic [DIV_CNT_W-1:0] RPM_STEPS  = DIV_CNT_W'(DIV_NUM_W);
    localparam int FREQ_ALIGN = DIV_NUM_W - FREQ_W;

    localparam logic [TCK_W-1:0] TCK_RESET = TCK_W'(84000000);
    localparam logic [EPC_W-1:0] EPC_RESET = EPC_W'(8);
    localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(16);
    localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(250);

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
    localparam logic [RPM_W-1:0]  RPM_MAX  = {1'b0, {(RPM_W-1){1'b1}}};

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CLOCK = 2'd0,
        CFG_EDGES       = 2'd1,
        CFG_PPR         = 2'd2,
        CFG_TIMEOUT     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TCK_W-1:0] timer_clock_hz;
        logic [EPC_W-1:0] edges_per_capture;
        logic [PPR_W-1:0] pulses_per_rev;
        logic [TMO_W-1:0] timeout_ms;
    } cfg_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_FDIV   = 6'b000100,
        ST_RSTART = 6'b001000,
        ST_RDIV   = 6'b010000,
        ST_DONE   = 6'b100000
    } seq_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/epsm_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Dividend is MSB-aligned; a shorter divide runs fewer steps. Uses epsm_pkg.
module epsm_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  epsm_pkg::div_ctl_t                 ctl,
    input  logic [epsm_pkg::DIV_NUM_W-1:0]     dividend,
    input  logic [epsm_pkg::DIV_DEN_W-1:0]     divisor,
    output logic [epsm_pkg::DIV_NUM_W-1:0]     quotient,
    output epsm_pkg::div_stat_t                stat
);
    import epsm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] dvs_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W+1:0] diff;
    logic                 q_bit;
    logic [DIV_DEN_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, q_reg[DIV_NUM_W-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        q_bit    = ~diff[DIV_DEN_W+1];
        rem_next = q_bit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            cnt_reg <= ctl.steps;
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            q_reg   <= {q_reg[DIV_NUM_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/epsm_seq.sv */
// Measurement state and item sequencer: capture phases, idle timeout,
// and the two divides (frequency, then RPM) on the shared divider. Uses epsm_pkg.
module epsm_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  epsm_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_op,
    input  logic [epsm_pkg::CAP_W-1:0]        in_cap,
    input  logic                              in_dir,
    output epsm_pkg::div_ctl_t                div_ctl,
    output logic [epsm_pkg::DIV_NUM_W-1:0]    div_dividend,
    output logic [epsm_pkg::DIV_DEN_W-1:0]    div_divisor,
    input  logic [epsm_pkg::DIV_NUM_W-1:0]    div_quotient,
    input  epsm_pkg::div_stat_t               div_stat,
    output logic                              res_valid,
    input  logic                              res_take,
    output logic [epsm_pkg::RPM_W-1:0]        res_rpm,
    output logic [epsm_pkg::FREQ_W-1:0]       res_freq
);
    import epsm_pkg::*;

    seq_state_t          state_reg, state_next;
    logic                phase_reg, phase_next;
    logic [CAP_W-1:0]    ts_reg, ts_next;
    logic [CAP_W-1:0]    period_reg, period_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic                ccw_reg, ccw_next;
    logic [IDLE_W-1:0]   idle_reg, idle_next;

    logic                op_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic                dir_reg;
    logic [RPM_W-1:0]    rpm_reg, rpm_next;

    logic [CAP_W-1:0]    period_new;
    logic [FREQ_W-1:0]   num;
    logic [PPR_W-1:0]    ppr_eff;
    logic [RPM_W-1:0]    mag;

    always_comb begin
        period_new = (cap_reg != ts_reg) ? cap_reg - ts_reg : period_reg;
        // max 28-bit clock times 4-bit prescaler still fits 32 bits
        num        = FREQ_W'(cfg.timer_clock_hz) * FREQ_W'(cfg.edges_per_capture);
        ppr_eff    = (cfg.pulses_per_rev == '0) ? PPR_W'(1) : cfg.pulses_per_rev;
        mag        = (div_quotient[DIV_NUM_W-1:RPM_W-1] != '0) ? RPM_MAX
                                                               : div_quotient[RPM_W-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        ts_next      = ts_reg;
        period_next  = period_reg;
        freq_next    = freq_reg;
        ccw_next     = ccw_reg;
        idle_next    = idle_reg;
        rpm_next     = rpm_reg;
        div_ctl      = '0;
        div_dividend = '0;
        div_divisor  = '0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = ST_RSTART;
                if (op_reg == OP_TICK) begin
                    idle_next = (idle_reg != IDLE_MAX) ? idle_reg + IDLE_W'(1) : idle_reg;
                    if (idle_next > cfg.timeout_ms) freq_next = '0;
                end else begin
                    idle_next = '0;
                    if (!phase_reg) begin
                        ts_next    = cap_reg;
                        phase_next = 1'b1;
                    end else begin
                        ccw_next    = dir_reg;
                        period_next = period_new;
                        phase_next  = 1'b0;
                        if (period_new == '0) begin
                            freq_next = '0;
                        end else begin
                            div_ctl.start = 1'b1;
                            div_ctl.steps = FREQ_STEPS;
                            div_dividend  = {num, {FREQ_ALIGN{1'b0}}};
                            div_divisor   = period_new;
                            state_next    = ST_FDIV;
                        end
                    end
                end
            end
            ST_FDIV: begin
                if (div_stat.done) begin
                    freq_next  = div_quotient[FREQ_W-1:0];
                    state_next = ST_RSTART;
                end
            end
            ST_RSTART: begin
                // freq * 60 = freq * 64 - freq * 4
                div_ctl.start = 1'b1;
                div_ctl.steps = RPM_STEPS;
                div_dividend  = {freq_reg, 6'b000000} - {4'b0000, freq_reg, 2'b00};
                div_divisor   = DIV_DEN_W'(ppr_eff);
                state_next    = ST_RDIV;
            end
            ST_RDIV: begin
                if (div_stat.done) begin
                    rpm_next   = ccw_reg ? RPM_W'(0) - mag : mag;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_take) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= 1'b0;
            ts_reg     <= '0;
            period_reg <= '0;
            freq_reg   <= '0;
            ccw_reg    <= 1'b0;
            idle_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ts_reg     <= ts_next;
            period_reg <= period_next;
            freq_reg   <= freq_next;
            ccw_reg    <= ccw_next;
            idle_reg   <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            op_reg  <= in_op;
            cap_reg <= in_cap;
            dir_reg <= in_dir;
        end
        rpm_reg <= rpm_next;
    end

    assign res_rpm  = rpm_reg;
    assign res_freq = freq_reg;

endmodule

/* rtl/encoder_period_speed_meter_unit.sv */
// Encoder period speed meter, top level: configuration registers,
// output word register, sequencer and serial divider. Uses epsm_pkg, epsm_seq, epsm_div.
//
// One word in, one word out. A tick, a first-phase capture or a zero-period capture
// runs only the 38-step RPM divide. A second-phase capture with a nonzero period
// runs a 32-step frequency divide and then the 38-step RPM
// divide on the same bit-serial divider (one quotient bit per clock). The next
// word is accepted once the result is in the output register, even while
// that result still waits; no new word is taken while one is still in work.
// Configuration writes are taken in any cycle but are meant for an idle block.
module encoder_period_speed_meter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [epsm_pkg::CAP_W-1:0]          s_capture_value,
    input  logic                                s_dir_pin,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [epsm_pkg::RPM_W-1:0]   m_speed_rpm,
    output logic [epsm_pkg::FREQ_W-1:0]         m_frequency_hz,
    output logic                                m_stopped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [epsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [epsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import epsm_pkg::*;

    cfg_t                 cfg_reg;
    logic                 m_valid_reg;
    logic [RPM_W-1:0]     rpm_out_reg;
    logic [FREQ_W-1:0]    freq_out_reg;
    logic                 stopped_out_reg;

    div_ctl_t             div_ctl;
    div_stat_t            div_stat;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic [DIV_NUM_W-1:0] div_quotient;

    logic                 res_valid;
    logic                 res_take;
    logic [RPM_W-1:0]     res_rpm;
    logic [FREQ_W-1:0]    res_freq;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timer_clock_hz    <= TCK_RESET;
            cfg_reg.edges_per_capture <= EPC_RESET;
            cfg_reg.pulses_per_rev    <= PPR_RESET;
            cfg_reg.timeout_ms        <= TMO_RESET;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIMER_CLOCK: cfg_reg.timer_clock_hz    <= cfg_data[TCK_W-1:0];
                CFG_EDGES:       cfg_reg.edges_per_capture <= cfg_data[EPC_W-1:0];
                CFG_PPR:         cfg_reg.pulses_per_rev    <= cfg_data[PPR_W-1:0];
                CFG_TIMEOUT:     cfg_reg.timeout_ms        <= cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // output word register: free when empty or being taken this cycle
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            rpm_out_reg     <= res_rpm;
            freq_out_reg    <= res_freq;
            stopped_out_reg <= (res_freq == '0);
        end
    end

    epsm_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_op        (s_op),
        .in_cap       (s_capture_value),
        .in_dir       (s_dir_pin),
        .div_ctl      (div_ctl),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quotient (div_quotient),
        .div_stat     (div_stat),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res_rpm      (res_rpm),
        .res_freq     (res_freq)
    );

    epsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign m_valid        = m_valid_reg;
    assign m_speed_rpm    = rpm_out_reg;
    assign m_frequency_hz = freq_out_reg;
    assign m_stopped      = stopped_out_reg;

endmodule
